>>> design/assert_macros.svh
// Assertion helpers for the RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef ASSERT_OFF

// Condition holds at every clock edge out of reset
`define ASSERT_ALWAYS(name, clk, rst_n, cond) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (cond)) \
    else $error("assertion failed: name");

// Consequent holds whenever the antecedent holds
`define ASSERT_IMPLIES(name, clk, rst_n, ante, cons) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("assertion failed: name");

`else

`define ASSERT_ALWAYS(name, clk, rst_n, cond)
`define ASSERT_IMPLIES(name, clk, rst_n, ante, cons)

`endif

`endif

>>> design/hjc_pkg.sv
package hjc_pkg;

  localparam logic [15:0] SYL_BASE    = 16'hAC00;
  localparam logic [15:0] SYL_END     = 16'hD7A4;
  localparam logic [15:0] VOWEL_FIRST = 16'h314F;
  localparam logic [15:0] VOWEL_LAST  = 16'h3163;
  localparam int          NUM_L       = 19;
  localparam int          NUM_V       = 21;
  localparam int          NUM_T       = 28;
  localparam int          LV_STEP     = NUM_V * NUM_T;

  // Reciprocals for the constant divisions: (s/4)*RECIP_7 >> 14 and x*RECIP_21 >> 16
  localparam logic [11:0] RECIP_7     = 12'd2341;
  localparam logic [11:0] RECIP_21    = 12'd3121;

  localparam int          FIFO_DEPTH  = 4;

  typedef struct packed {
    logic       hit;
    logic [4:0] idx;
  } idx_t;

  typedef struct packed {
    logic [4:0] keep;
    logic [4:0] ml;
  } split_t;

  // Pending character with its syllable decomposition
  typedef struct packed {
    logic        valid;
    logic [15:0] code;
    logic        syl;
    logic [4:0]  l;
    logic [4:0]  v;
    logic [4:0]  t;
  } pend_t;

  // Incoming request with the decomposition of its code
  typedef struct packed {
    logic [15:0] code;
    logic        last;
    logic        syl;
    logic [4:0]  l;
    logic [4:0]  v;
    logic [4:0]  t;
  } item_t;

  typedef struct packed {
    logic [15:0] code;
    logic        last;
  } result_t;

  function automatic logic [15:0] make_code(logic [4:0] l, logic [4:0] v, logic [4:0] t);
    return SYL_BASE + {11'd0, l} * 16'(LV_STEP) + {11'd0, v} * 16'(NUM_T) + {11'd0, t};
  endfunction

  function automatic pend_t make_pend(logic [4:0] l, logic [4:0] v, logic [4:0] t);
    pend_t p;
    p.valid = 1'b1;
    p.code  = make_code(l, v, t);
    p.syl   = 1'b1;
    p.l     = l;
    p.v     = v;
    p.t     = t;
    return p;
  endfunction

  function automatic idx_t lead_lookup(logic [15:0] c);
    idx_t r;
    r.hit = 1'b1;
    r.idx = 5'd0;
    case (c)
      16'h3131: r.idx = 5'd0;
      16'h3132: r.idx = 5'd1;
      16'h3134: r.idx = 5'd2;
      16'h3137: r.idx = 5'd3;
      16'h3138: r.idx = 5'd4;
      16'h3139: r.idx = 5'd5;
      16'h3141: r.idx = 5'd6;
      16'h3142: r.idx = 5'd7;
      16'h3143: r.idx = 5'd8;
      16'h3145: r.idx = 5'd9;
      16'h3146: r.idx = 5'd10;
      16'h3147: r.idx = 5'd11;
      16'h3148: r.idx = 5'd12;
      16'h3149: r.idx = 5'd13;
      16'h314A: r.idx = 5'd14;
      16'h314B: r.idx = 5'd15;
      16'h314C: r.idx = 5'd16;
      16'h314D: r.idx = 5'd17;
      16'h314E: r.idx = 5'd18;
      default:  r.hit = 1'b0;
    endcase
    return r;
  endfunction

  // Final index of a jamo, zero when it cannot stand as a final
  function automatic logic [4:0] tail_lookup(logic [15:0] c);
    logic [4:0] r;
    r = 5'd0;
    case (c)
      16'h3131: r = 5'd1;
      16'h3132: r = 5'd2;
      16'h3133: r = 5'd3;
      16'h3134: r = 5'd4;
      16'h3135: r = 5'd5;
      16'h3136: r = 5'd6;
      16'h3137: r = 5'd7;
      16'h3139: r = 5'd8;
      16'h313A: r = 5'd9;
      16'h313B: r = 5'd10;
      16'h313C: r = 5'd11;
      16'h313D: r = 5'd12;
      16'h313E: r = 5'd13;
      16'h313F: r = 5'd14;
      16'h3140: r = 5'd15;
      16'h3141: r = 5'd16;
      16'h3142: r = 5'd17;
      16'h3144: r = 5'd18;
      16'h3145: r = 5'd19;
      16'h3146: r = 5'd20;
      16'h3147: r = 5'd21;
      16'h3148: r = 5'd22;
      16'h314A: r = 5'd23;
      16'h314B: r = 5'd24;
      16'h314C: r = 5'd25;
      16'h314D: r = 5'd26;
      16'h314E: r = 5'd27;
      default:  r = 5'd0;
    endcase
    return r;
  endfunction

  function automatic idx_t dvowel_lookup(logic [4:0] v1, logic [4:0] v2);
    idx_t r;
    r.hit = 1'b1;
    r.idx = 5'd0;
    case ({v1, v2})
      {5'd8, 5'd0}:   r.idx = 5'd9;
      {5'd8, 5'd1}:   r.idx = 5'd10;
      {5'd8, 5'd20}:  r.idx = 5'd11;
      {5'd13, 5'd4}:  r.idx = 5'd14;
      {5'd13, 5'd5}:  r.idx = 5'd15;
      {5'd13, 5'd20}: r.idx = 5'd16;
      {5'd18, 5'd20}: r.idx = 5'd19;
      default:        r.hit = 1'b0;
    endcase
    return r;
  endfunction

  function automatic idx_t dfinal_lookup(logic [4:0] t1, logic [4:0] t2);
    idx_t r;
    r.hit = 1'b1;
    r.idx = 5'd0;
    case ({t1, t2})
      {5'd1, 5'd19}:  r.idx = 5'd3;
      {5'd4, 5'd22}:  r.idx = 5'd5;
      {5'd4, 5'd27}:  r.idx = 5'd6;
      {5'd8, 5'd1}:   r.idx = 5'd9;
      {5'd8, 5'd16}:  r.idx = 5'd10;
      {5'd8, 5'd17}:  r.idx = 5'd11;
      {5'd8, 5'd19}:  r.idx = 5'd12;
      {5'd8, 5'd25}:  r.idx = 5'd13;
      {5'd8, 5'd26}:  r.idx = 5'd14;
      {5'd8, 5'd27}:  r.idx = 5'd15;
      {5'd17, 5'd19}: r.idx = 5'd18;
      default:        r.hit = 1'b0;
    endcase
    return r;
  endfunction

  // Final that stays behind and initial that moves on when a vowel follows
  function automatic split_t split_final(logic [4:0] t);
    split_t r;
    r.keep = 5'd0;
    r.ml   = 5'd0;
    case (t)
      5'd2:  r.ml = 5'd1;
      5'd3:  begin r.keep = 5'd1;  r.ml = 5'd9;  end
      5'd4:  r.ml = 5'd2;
      5'd5:  begin r.keep = 5'd4;  r.ml = 5'd12; end
      5'd6:  begin r.keep = 5'd4;  r.ml = 5'd18; end
      5'd7:  r.ml = 5'd3;
      5'd8:  r.ml = 5'd5;
      5'd9:  begin r.keep = 5'd8;  r.ml = 5'd0;  end
      5'd10: begin r.keep = 5'd8;  r.ml = 5'd6;  end
      5'd11: begin r.keep = 5'd8;  r.ml = 5'd7;  end
      5'd12: begin r.keep = 5'd8;  r.ml = 5'd9;  end
      5'd13: begin r.keep = 5'd8;  r.ml = 5'd16; end
      5'd14: begin r.keep = 5'd8;  r.ml = 5'd17; end
      5'd15: begin r.keep = 5'd8;  r.ml = 5'd18; end
      5'd16: r.ml = 5'd6;
      5'd17: r.ml = 5'd7;
      5'd18: begin r.keep = 5'd17; r.ml = 5'd9;  end
      5'd19: r.ml = 5'd9;
      5'd20: r.ml = 5'd10;
      5'd21: r.ml = 5'd11;
      5'd22: r.ml = 5'd12;
      5'd23: r.ml = 5'd14;
      5'd24: r.ml = 5'd15;
      5'd25: r.ml = 5'd16;
      5'd26: r.ml = 5'd17;
      5'd27: r.ml = 5'd18;
      default: r.ml = 5'd0;
    endcase
    return r;
  endfunction

endpackage

>>> design/hjc_compose.sv
module hjc_compose (
  input  hjc_pkg::pend_t   pend,
  input  hjc_pkg::item_t   item,
  output hjc_pkg::pend_t   pend_nxt,
  output hjc_pkg::result_t res0,
  output hjc_pkg::result_t res1,
  output logic [1:0]       res_cnt
);
  import hjc_pkg::*;

  idx_t       lead_p;
  idx_t       dv;
  idx_t       df;
  split_t     sp;
  logic [4:0] ti;
  logic [4:0] vi;
  logic       vw;
  logic       done;
  pend_t      raw;
  pend_t      merged;

  // Classify the incoming code against the pending character
  always_comb begin
    raw.valid = 1'b1;
    raw.code  = item.code;
    raw.syl   = item.syl;
    raw.l     = item.l;
    raw.v     = item.v;
    raw.t     = item.t;
    lead_p    = lead_lookup(pend.code);
    ti        = tail_lookup(item.code);
    vw        = (item.code >= VOWEL_FIRST) && (item.code <= VOWEL_LAST);
    vi        = 5'(item.code - VOWEL_FIRST);
    dv        = dvowel_lookup(pend.v, vi);
    df        = dfinal_lookup(pend.t, ti);
    sp        = split_final(pend.t);
  end

  // Merge, close or split the pending character, then flush on last
  always_comb begin
    merged    = pend;
    done      = 1'b0;
    res0.code = pend.code;
    res0.last = 1'b0;
    res1.code = 16'd0;
    res1.last = 1'b0;
    res_cnt   = 2'd0;
    if (!pend.valid) begin
      merged = raw;
      done   = 1'b1;
    end else if (lead_p.hit && vw) begin
      merged = make_pend(lead_p.idx, vi, 5'd0);
      done   = 1'b1;
    end else if (pend.syl) begin
      if (pend.t == 5'd0 && ti != 5'd0) begin
        merged.t    = ti;
        merged.code = pend.code + {11'd0, ti};
        done        = 1'b1;
      end else if (pend.t == 5'd0 && vw) begin
        if (dv.hit) begin
          merged = make_pend(pend.l, dv.idx, 5'd0);
          done   = 1'b1;
        end
      end else if (pend.t != 5'd0 && ti != 5'd0) begin
        if (df.hit) begin
          merged = make_pend(pend.l, pend.v, df.idx);
          done   = 1'b1;
        end
      end else if (pend.t != 5'd0 && vw) begin
        res0.code = make_code(pend.l, pend.v, sp.keep);
        res_cnt   = 2'd1;
        merged    = make_pend(sp.ml, vi, 5'd0);
        done      = 1'b1;
      end
    end
    if (!done) begin
      res0.code = pend.code;
      res_cnt   = 2'd1;
      merged    = raw;
    end
    if (item.last) begin
      if (res_cnt == 2'd0) begin
        res0.code = merged.code;
        res0.last = 1'b1;
      end else begin
        res1.code = merged.code;
        res1.last = 1'b1;
      end
      res_cnt = res_cnt + 2'd1;
      merged  = '0;
    end
    pend_nxt = merged;
  end

endmodule

>>> design/hangul_jamo_composer_unit.sv
// Hangul jamo composer. Takes one 16-bit code unit per request and holds one
// pending character, building precomposed syllables from compatibility jamo;
// the last flag flushes that character with out_last set. A request runs
// through three register stages (input, syllable decomposition, compose)
// and its results enter a four-entry result queue that feeds the output.
// One request is taken per cycle while in_stall is low; a request yields
// zero, one or two results, and the queue drains one result per cycle while
// out_stall is low, so requests that close a character and flush at once
// yield two results to drain. The input stalls while the queue holds more
// than two results.
`include "assert_macros.svh"

module hangul_jamo_composer_unit (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [15:0] in_code,
  input  logic        in_last,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [15:0] out_code,
  output logic        out_last
);
  import hjc_pkg::*;

  localparam int PTR_W = $clog2(FIFO_DEPTH);
  localparam int CNT_W = $clog2(FIFO_DEPTH + 1);

  logic              adv;
  logic              fire;
  logic              pop;

  logic              s1_valid_r;
  logic [15:0]       s1_code_r;
  logic              s1_last_r;

  logic [13:0]       s1_off;
  logic [23:0]       s1_prod;

  logic              s2_valid_r;
  logic [15:0]       s2_code_r;
  logic              s2_last_r;
  logic              s2_syl_r;
  logic [13:0]       s2_off_r;
  logic [8:0]        s2_st_r;

  logic [20:0]       s2_prod;
  logic [4:0]        s2_l;
  item_t             item;

  pend_t             pend_r;
  pend_t             pend_nxt;
  result_t           res0;
  result_t           res1;
  logic [1:0]        res_cnt;

  result_t           fifo_r [FIFO_DEPTH];
  logic [PTR_W-1:0]  wr_ptr_r;
  logic [PTR_W-1:0]  rd_ptr_r;
  logic [CNT_W-1:0]  cnt_r;
  logic [1:0]        push_n;

  // Advance the pipeline only while the queue can absorb two results
  assign adv      = cnt_r <= CNT_W'(FIFO_DEPTH - 2);
  assign in_stall = !adv;
  assign fire     = s2_valid_r && adv;
  assign pop      = out_valid && !out_stall;
  assign push_n   = fire ? res_cnt : 2'd0;

  // Syllable offset divided by 28: quarter it, then scale by the reciprocal of 7
  assign s1_off  = s1_code_r[13:0] - SYL_BASE[13:0];
  assign s1_prod = {12'd0, s1_off[13:2]} * {12'd0, RECIP_7};

  // Split the quotient into initial and vowel, the remainder is the final
  assign s2_prod = 21'(s2_st_r) * 21'(RECIP_21);
  assign s2_l    = s2_prod[20:16];

  always_comb begin
    item.code = s2_code_r;
    item.last = s2_last_r;
    item.syl  = s2_syl_r;
    item.l    = s2_l;
    item.v    = 5'(s2_st_r - 9'(s2_l) * 9'(NUM_V));
    item.t    = 5'(s2_off_r - 14'(s2_st_r) * 14'(NUM_T));
  end

  hjc_compose u_compose (
    .pend     (pend_r),
    .item     (item),
    .pend_nxt (pend_nxt),
    .res0     (res0),
    .res1     (res1),
    .res_cnt  (res_cnt)
  );

  // Hold or advance the request stages and the pending character
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
      s2_valid_r <= 1'b0;
      pend_r     <= '0;
    end else if (adv) begin
      s1_valid_r <= in_valid;
      s2_valid_r <= s1_valid_r;
      if (fire) begin
        pend_r <= pend_nxt;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      s1_code_r <= in_code;
      s1_last_r <= in_last;
      s2_code_r <= s1_code_r;
      s2_last_r <= s1_last_r;
      s2_syl_r  <= (s1_code_r >= SYL_BASE) && (s1_code_r < SYL_END);
      s2_off_r  <= s1_off;
      s2_st_r   <= s1_prod[22:14];
    end
  end

  // Push up to two results, drop the head when taken
  always_ff @(posedge clk) begin
    if (push_n != 2'd0) begin
      fifo_r[wr_ptr_r] <= res0;
    end
    if (push_n == 2'd2) begin
      fifo_r[wr_ptr_r + PTR_W'(1)] <= res1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_r + PTR_W'(push_n);
      rd_ptr_r <= rd_ptr_r + PTR_W'(pop);
      cnt_r    <= cnt_r + CNT_W'(push_n) - CNT_W'(pop);
    end
  end

  assign out_valid = cnt_r != '0;
  assign out_code  = fifo_r[rd_ptr_r].code;
  assign out_last  = fifo_r[rd_ptr_r].last;

  `ASSERT_ALWAYS(a_cnt_bound, clk, rst_n, cnt_r <= CNT_W'(FIFO_DEPTH))
  `ASSERT_IMPLIES(a_push_fits, clk, rst_n, fire, (4'(cnt_r) + 4'(res_cnt)) <= 4'(FIFO_DEPTH))
  `ASSERT_IMPLIES(a_idle_pend_clear, clk, rst_n, !pend_r.valid, pend_r.code == 16'd0)
  `ASSERT_IMPLIES(a_syl_fields, clk, rst_n, pend_r.valid && pend_r.syl, (pend_r.l < 5'(NUM_L)) && (pend_r.v < 5'(NUM_V)) && (pend_r.t < 5'(NUM_T)))

endmodule
